// File: src/qte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, arctangent table and helpers for the quaternion to
// ZYX Euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int COMPONENT_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF     = 16;

  // Components are cut to at most this many bits (Q2.15) before products.
  localparam int WORK_MAX     = 17;
  // CORDIC datapath: normalized magnitude lies in [2^40, 2^41), gain < 2.33.
  localparam int CORDIC_W     = 45;
  localparam int NORM_EXP     = 40;
  localparam int NORM_STAGES  = 6;
  localparam int CORDIC_STEPS = 32;
  localparam int TURN_W       = 32;
  // prep + normalize + CORDIC + round
  localparam int ATAN_LAT     = 1 + NORM_STAGES + CORDIC_STEPS + 1;

  typedef logic [TURN_W-1:0] turn_t;

  localparam turn_t HALF_TURN = 32'h8000_0000;

  localparam turn_t ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  function automatic int work_bits(input int comp_bits);
    return (comp_bits > WORK_MAX) ? WORK_MAX : comp_bits;
  endfunction

  // width of a rotation matrix term
  function automatic int term_bits(input int comp_bits);
    return 2 * work_bits(comp_bits) + 2;
  endfunction

  // number of square root steps, also the root width
  function automatic int root_steps(input int comp_bits);
    return 2 * (work_bits(comp_bits) - 2) + 1;
  endfunction

  // true when -2^t < v < 2^t
  function automatic logic fits(input logic signed [CORDIC_W-1:0] v, input int t);
    logic signed [CORDIC_W-1:0] lim;
    lim    = '0;
    lim[t] = 1'b1;
    return (v < lim) && (v > -lim);
  endfunction

endpackage

// File: src/qte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_if
// Valid/ready channels: quaternion words in, Euler angle words out.
// ----------------------------------------------------------------------------
interface qte_quat_if #(
  parameter int COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] quat_x;
  logic signed [COMPONENT_BITS-1:0] quat_y;
  logic signed [COMPONENT_BITS-1:0] quat_z;
  logic signed [COMPONENT_BITS-1:0] quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_angle_if #(
  parameter int ANGLE_BITS = qte_pkg::ANGLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] yaw_angle;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

// File: src/qte_terms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_terms
// Four stages: trim components, form products, sum matrix terms, then the
// pitch saturation flags and the (1-s)(1+s) square root argument.
// ----------------------------------------------------------------------------
module qte_terms #(
  parameter int COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF,
  parameter int TERM_W         = qte_pkg::term_bits(qte_pkg::COMPONENT_BITS_DEF),
  parameter int ROOT_STEPS     = qte_pkg::root_steps(qte_pkg::COMPONENT_BITS_DEF)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             vld_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_x_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_y_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_z_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_w_i,
  output logic                             vld_o,
  output logic signed [TERM_W-1:0]         roll_y_o,
  output logic signed [TERM_W-1:0]         roll_x_o,
  output logic signed [TERM_W-1:0]         yaw_y_o,
  output logic signed [TERM_W-1:0]         yaw_x_o,
  output logic signed [TERM_W-1:0]         sin_o,
  output logic                             sat_pos_o,
  output logic                             sat_neg_o,
  output logic [2*ROOT_STEPS-1:0]          root_arg_o
);

  localparam int WB = qte_pkg::work_bits(COMPONENT_BITS);
  localparam int PB = 2 * WB;
  localparam int PW = 2 * ROOT_STEPS;
  localparam logic signed [TERM_W-1:0] ONE = {{(TERM_W-1){1'b0}}, 1'b1} << (2 * (WB - 2));

  logic [3:0] vld_q;

  logic signed [WB-1:0] x_q, y_q, z_q, w_q;
  logic signed [PB-1:0] p_xx_q, p_yy_q, p_zz_q, p_yz_q, p_wx_q;
  logic signed [PB-1:0] p_xz_q, p_wy_q, p_xy_q, p_wz_q;
  logic signed [TERM_W-1:0] r21_q, r22_q, s_q, r10_q, r00_q;
  logic signed [TERM_W-1:0] one_m_s, one_p_s;

  assign one_m_s = ONE - s_q;
  assign one_p_s = ONE + s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // keep the top bits: floor shift to the working precision
      x_q <= quat_x_i[COMPONENT_BITS-1 -: WB];
      y_q <= quat_y_i[COMPONENT_BITS-1 -: WB];
      z_q <= quat_z_i[COMPONENT_BITS-1 -: WB];
      w_q <= quat_w_i[COMPONENT_BITS-1 -: WB];

      p_xx_q <= PB'(x_q) * PB'(x_q);
      p_yy_q <= PB'(y_q) * PB'(y_q);
      p_zz_q <= PB'(z_q) * PB'(z_q);
      p_yz_q <= PB'(y_q) * PB'(z_q);
      p_wx_q <= PB'(w_q) * PB'(x_q);
      p_xz_q <= PB'(x_q) * PB'(z_q);
      p_wy_q <= PB'(w_q) * PB'(y_q);
      p_xy_q <= PB'(x_q) * PB'(y_q);
      p_wz_q <= PB'(w_q) * PB'(z_q);

      r21_q <= (TERM_W'(p_yz_q) + TERM_W'(p_wx_q)) <<< 1;
      r22_q <= ONE - ((TERM_W'(p_xx_q) + TERM_W'(p_yy_q)) <<< 1);
      s_q   <= (TERM_W'(p_wy_q) - TERM_W'(p_xz_q)) <<< 1;
      r10_q <= (TERM_W'(p_xy_q) + TERM_W'(p_wz_q)) <<< 1;
      r00_q <= ONE - ((TERM_W'(p_yy_q) + TERM_W'(p_zz_q)) <<< 1);

      roll_y_o   <= r21_q;
      roll_x_o   <= r22_q;
      yaw_y_o    <= r10_q;
      yaw_x_o    <= r00_q;
      sin_o      <= s_q;
      sat_pos_o  <= (s_q >= ONE);
      sat_neg_o  <= (s_q <= -ONE);
      // both factors lie in (0, 2) when not saturated
      root_arg_o <= PW'(one_m_s[ROOT_STEPS-1:0]) * PW'(one_p_s[ROOT_STEPS-1:0]);
    end
  end

  assign vld_o = vld_q[3];

endmodule

// File: src/qte_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined restoring integer square root, one result bit per stage, with a
// side word carried alongside.
// ----------------------------------------------------------------------------
module qte_isqrt #(
  parameter int ROOT_STEPS = qte_pkg::root_steps(qte_pkg::COMPONENT_BITS_DEF),
  parameter int SIDE_W     = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [2*ROOT_STEPS-1:0] arg_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    vld_o,
  output logic [ROOT_STEPS-1:0]   root_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam int PW = 2 * ROOT_STEPS;

  logic              vld_q  [ROOT_STEPS];
  logic [PW-1:0]     v_q    [ROOT_STEPS];
  logic [PW-1:0]     r_q    [ROOT_STEPS];
  logic [SIDE_W-1:0] side_q [ROOT_STEPS];

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
    localparam logic [PW-1:0] BIT = {{(PW-1){1'b0}}, 1'b1} << (2 * (ROOT_STEPS - 1 - j));

    logic              vl_in;
    logic [PW-1:0]     v_in;
    logic [PW-1:0]     r_in;
    logic [PW-1:0]     rb;
    logic [SIDE_W-1:0] s_in;

    if (j == 0) begin : g_first
      assign vl_in = vld_i;
      assign v_in  = arg_i;
      assign r_in  = '0;
      assign s_in  = side_i;
    end else begin : g_next
      assign vl_in = vld_q[j-1];
      assign v_in  = v_q[j-1];
      assign r_in  = r_q[j-1];
      assign s_in  = side_q[j-1];
    end

    assign rb = r_in + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= s_in;
        if (v_in >= rb) begin
          v_q[j] <= v_in - rb;
          r_q[j] <= (r_in >> 1) + BIT;
        end else begin
          v_q[j] <= v_in;
          r_q[j] <= r_in >> 1;
        end
      end
    end
  end

  assign vld_o  = vld_q[ROOT_STEPS-1];
  assign root_o = r_q[ROOT_STEPS-1][ROOT_STEPS-1:0];
  assign side_o = side_q[ROOT_STEPS-1];

endmodule

// File: src/qte_atan2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_atan2
// Full-quadrant atan2 lane: half-plane fold, staged normalize, 32 unrolled
// CORDIC vectoring stages and a rounding stage. An override word replaces
// the result when requested or when the vector is zero.
// ----------------------------------------------------------------------------
module qte_atan2 #(
  parameter int TERM_W     = qte_pkg::term_bits(qte_pkg::COMPONENT_BITS_DEF),
  parameter int ANGLE_BITS = qte_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [TERM_W-1:0]     y_i,
  input  logic signed [TERM_W-1:0]     x_i,
  input  logic                         ovr_i,
  input  logic [ANGLE_BITS-1:0]        ovr_val_i,
  output logic signed [ANGLE_BITS-1:0] angle_o
);

  localparam int CW = qte_pkg::CORDIC_W;
  localparam int NS = qte_pkg::NORM_STAGES;
  localparam int CS = qte_pkg::CORDIC_STEPS;
  localparam int TW = qte_pkg::TURN_W;
  localparam logic [TW:0] RND = ({{TW{1'b0}}, 1'b1} << (TW - ANGLE_BITS)) >> 1;

  logic signed [CW-1:0] xe, ye;
  logic signed [CW-1:0] px_q, py_q;
  qte_pkg::turn_t       pz_q;
  logic                 povr_q;
  logic [ANGLE_BITS-1:0] pval_q;

  logic signed [CW-1:0]  nx_q   [NS];
  logic signed [CW-1:0]  ny_q   [NS];
  qte_pkg::turn_t        nz_q   [NS];
  logic                  novr_q [NS];
  logic [ANGLE_BITS-1:0] nval_q [NS];

  logic signed [CW-1:0]  cx_q   [CS];
  logic signed [CW-1:0]  cy_q   [CS];
  qte_pkg::turn_t        cz_q   [CS];
  logic                  covr_q [CS];
  logic [ANGLE_BITS-1:0] cval_q [CS];

  logic [TW:0] rnd_sum;

  assign xe = CW'(x_i);
  assign ye = CW'(y_i);

  // fold the left half plane onto the right one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      povr_q <= ovr_i || ((x_i == '0) && (y_i == '0));
      pval_q <= ovr_i ? ovr_val_i : '0;
      if (x_i < 0) begin
        px_q <= -xe;
        py_q <= -ye;
        pz_q <= qte_pkg::HALF_TURN;
      end else begin
        px_q <= xe;
        py_q <= ye;
        pz_q <= '0;
      end
    end
  end

  // shift left until one magnitude reaches 2^NORM_EXP
  for (genvar n = 0; n < NS; n++) begin : g_norm
    localparam int K = 32 >> n;
    localparam int T = qte_pkg::NORM_EXP - K;

    logic signed [CW-1:0]  x_in, y_in;
    qte_pkg::turn_t        z_in;
    logic                  o_in;
    logic [ANGLE_BITS-1:0] v_in;
    logic                  low_mag;

    if (n == 0) begin : g_first
      assign x_in = px_q;
      assign y_in = py_q;
      assign z_in = pz_q;
      assign o_in = povr_q;
      assign v_in = pval_q;
    end else begin : g_next
      assign x_in = nx_q[n-1];
      assign y_in = ny_q[n-1];
      assign z_in = nz_q[n-1];
      assign o_in = novr_q[n-1];
      assign v_in = nval_q[n-1];
    end

    assign low_mag = qte_pkg::fits(x_in, T) && qte_pkg::fits(y_in, T);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nz_q[n]   <= z_in;
        novr_q[n] <= o_in;
        nval_q[n] <= v_in;
        if (n == NS - 1) begin
          // last step adds the doubling that crosses the limit
          nx_q[n] <= low_mag ? (x_in <<< (K + 1)) : (x_in <<< 1);
          ny_q[n] <= low_mag ? (y_in <<< (K + 1)) : (y_in <<< 1);
        end else begin
          nx_q[n] <= low_mag ? (x_in <<< K) : x_in;
          ny_q[n] <= low_mag ? (y_in <<< K) : y_in;
        end
      end
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_rot
    logic signed [CW-1:0]  x_in, y_in, xs, ys;
    qte_pkg::turn_t        z_in;
    logic                  o_in;
    logic [ANGLE_BITS-1:0] v_in;

    if (i == 0) begin : g_first
      assign x_in = nx_q[NS-1];
      assign y_in = ny_q[NS-1];
      assign z_in = nz_q[NS-1];
      assign o_in = novr_q[NS-1];
      assign v_in = nval_q[NS-1];
    end else begin : g_next
      assign x_in = cx_q[i-1];
      assign y_in = cy_q[i-1];
      assign z_in = cz_q[i-1];
      assign o_in = covr_q[i-1];
      assign v_in = cval_q[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        covr_q[i] <= o_in;
        cval_q[i] <= v_in;
        if (y_in > 0) begin
          cx_q[i] <= x_in + ys;
          cy_q[i] <= y_in - xs;
          cz_q[i] <= z_in + qte_pkg::ATAN_TURN[i];
        end else begin
          cx_q[i] <= x_in - ys;
          cy_q[i] <= y_in + xs;
          cz_q[i] <= z_in - qte_pkg::ATAN_TURN[i];
        end
      end
    end
  end

  // round half up to the angle width, wrapping modulo one turn
  assign rnd_sum = {1'b0, cz_q[CS-1]} + RND;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_o <= covr_q[CS-1] ? cval_q[CS-1] : rnd_sum[TW-1 -: ANGLE_BITS];
    end
  end

endmodule

// File: src/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Unit quaternion (Q2.14) to ZYX Euler angles in binary angle units.
// ----------------------------------------------------------------------------
// Usage:
//   quat_i carries one quaternion word (quat_x, quat_y, quat_z, quat_w);
//   angle_o returns one word (roll_angle, pitch_angle, yaw_angle) per input
//   word, in order. A word moves when valid and ready are both high.
// Throughput: one word per cycle unless stalled; items are independent.
// Pipeline: the four term stages, R = 2 * min(COMPONENT_BITS, 17) - 3
//   square root stages (one result bit per stage) and the 40-stage atan2
//   lanes (fold, 6 normalize steps, 32 CORDIC steps, rounding) that run in
//   parallel, then the output buffer, lie between accept and angle_o.valid.
// Stall: a two-word output buffer holds finished words; quat_i.ready stays
//   high while it has a free slot and the whole pipeline holds when it is full.
// Reset: rst_ni clears all valid bits and the buffer; no word is in flight
//   afterwards and the block accepts on the next cycle.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
  parameter int COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF,
  parameter int ANGLE_BITS     = qte_pkg::ANGLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qte_quat_if.sink    quat_i,
  qte_angle_if.source angle_o
);

  localparam int TW     = qte_pkg::term_bits(COMPONENT_BITS);
  localparam int RS     = qte_pkg::root_steps(COMPONENT_BITS);
  localparam int SIDE_W = 5 * TW + 2;
  localparam int LAT    = qte_pkg::ATAN_LAT;
  localparam int OW     = 3 * ANGLE_BITS;
  localparam logic [ANGLE_BITS-1:0] QUARTER = {{(ANGLE_BITS-1){1'b0}}, 1'b1} << (ANGLE_BITS - 2);
  localparam logic [1:0] CNT_EMPTY = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_FULL  = 2'd2;

  logic adv, push, pop;

  logic                  t_vld;
  logic signed [TW-1:0]  t_roll_y, t_roll_x, t_yaw_y, t_yaw_x, t_sin;
  logic                  t_sat_pos, t_sat_neg;
  logic [2*RS-1:0]       t_root_arg;

  logic                  r_vld;
  logic [RS-1:0]         r_root;
  logic [SIDE_W-1:0]     r_side;
  logic signed [TW-1:0]  r_roll_y, r_roll_x, r_yaw_y, r_yaw_x, r_sin, r_cos;
  logic                  r_sat_pos, r_sat_neg;
  logic [ANGLE_BITS-1:0] pitch_sat_val;

  logic signed [ANGLE_BITS-1:0] roll_a, pitch_a, yaw_a;
  logic [LAT-1:0]        vld_a_q;
  logic [OW-1:0]         buf0_q, buf1_q, new_word;
  logic [1:0]            cnt_q;

  assign adv          = (cnt_q != CNT_FULL);
  assign quat_i.ready = adv;

  qte_terms #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .TERM_W         (TW),
    .ROOT_STEPS     (RS)
  ) u_terms (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .vld_i      (quat_i.valid),
    .quat_x_i   (quat_i.quat_x),
    .quat_y_i   (quat_i.quat_y),
    .quat_z_i   (quat_i.quat_z),
    .quat_w_i   (quat_i.quat_w),
    .vld_o      (t_vld),
    .roll_y_o   (t_roll_y),
    .roll_x_o   (t_roll_x),
    .yaw_y_o    (t_yaw_y),
    .yaw_x_o    (t_yaw_x),
    .sin_o      (t_sin),
    .sat_pos_o  (t_sat_pos),
    .sat_neg_o  (t_sat_neg),
    .root_arg_o (t_root_arg)
  );

  qte_isqrt #(
    .ROOT_STEPS (RS),
    .SIDE_W     (SIDE_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (t_vld),
    .arg_i  (t_root_arg),
    .side_i ({t_roll_y, t_roll_x, t_yaw_y, t_yaw_x, t_sin, t_sat_pos, t_sat_neg}),
    .vld_o  (r_vld),
    .root_o (r_root),
    .side_o (r_side)
  );

  assign {r_roll_y, r_roll_x, r_yaw_y, r_yaw_x, r_sin, r_sat_pos, r_sat_neg} = r_side;
  assign r_cos         = TW'(r_root);
  assign pitch_sat_val = r_sat_pos ? QUARTER : -QUARTER;

  qte_atan2 #(.TERM_W (TW), .ANGLE_BITS (ANGLE_BITS)) u_roll (
    .clk_i     (clk_i),
    .en_i      (adv),
    .y_i       (r_roll_y),
    .x_i       (r_roll_x),
    .ovr_i     (1'b0),
    .ovr_val_i ('0),
    .angle_o   (roll_a)
  );

  qte_atan2 #(.TERM_W (TW), .ANGLE_BITS (ANGLE_BITS)) u_pitch (
    .clk_i     (clk_i),
    .en_i      (adv),
    .y_i       (r_sin),
    .x_i       (r_cos),
    .ovr_i     (r_sat_pos || r_sat_neg),
    .ovr_val_i (pitch_sat_val),
    .angle_o   (pitch_a)
  );

  qte_atan2 #(.TERM_W (TW), .ANGLE_BITS (ANGLE_BITS)) u_yaw (
    .clk_i     (clk_i),
    .en_i      (adv),
    .y_i       (r_yaw_y),
    .x_i       (r_yaw_x),
    .ovr_i     (1'b0),
    .ovr_val_i ('0),
    .angle_o   (yaw_a)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= '0;
    end else if (adv) begin
      vld_a_q <= {vld_a_q[LAT-2:0], r_vld};
    end
  end

  // two-word output buffer
  assign push     = adv && vld_a_q[LAT-1];
  assign pop      = angle_o.valid && angle_o.ready;
  assign new_word = {roll_a, pitch_a, yaw_a};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_EMPTY;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      buf0_q <= (push && (cnt_q == CNT_ONE)) ? new_word : buf1_q;
    end else if (push) begin
      if (cnt_q == CNT_EMPTY) begin
        buf0_q <= new_word;
      end else begin
        buf1_q <= new_word;
      end
    end
  end

  assign angle_o.valid       = (cnt_q != CNT_EMPTY);
  assign angle_o.roll_angle  = buf0_q[OW-1 -: ANGLE_BITS];
  assign angle_o.pitch_angle = buf0_q[2*ANGLE_BITS-1 -: ANGLE_BITS];
  assign angle_o.yaw_angle   = buf0_q[ANGLE_BITS-1:0];

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q != CNT_FULL))
    else $error("word pushed into a full output buffer");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_a_q))
    else $error("pipeline moved while stalled");

endmodule
